/* design/pmdh_pkg.sv */
// Shared constants, codes and types of the peak meter with decay and hold.
// Depends on nothing; every other design file of the block but pmdh_ram imports it.
package pmdh_pkg;

    // Channel count and field widths.
    localparam int CHANNELS   = 8;
    localparam int CH_AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CHAN_W     = 3;
    localparam int LEVEL_W    = 8;
    localparam int TIME_W     = 32;
    localparam int DECAY_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Decay arithmetic: signed product and its magnitude.
    localparam int PROD_W     = DECAY_W + TIME_W + 1;
    localparam int MAG_W      = DECAY_W - 1 + TIME_W;
    localparam int DIV_CNT_W  = $clog2(MAG_W + 1);

    // Depth of the queue between front end and back end.
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    // Item kinds.
    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_DB   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS = 2'd2;

    // Configuration reset values.
    localparam logic signed [DECAY_W-1:0] DECAY_DB_RST = -8'sd55;
    localparam logic [TIME_W-1:0]         PERIOD_RST   = 32'd1500000;
    localparam logic [TIME_W-1:0]         HOLD_RST     = 32'd300000;

    // Bar clamp limits at product width.
    localparam logic signed [PROD_W-1:0] SUM_MIN = -(2 ** (LEVEL_W - 1));
    localparam logic signed [PROD_W-1:0] SUM_MAX = (2 ** (LEVEL_W - 1)) - 1;

    typedef logic [CHAN_W-1:0]         chan_t;
    typedef logic signed [LEVEL_W-1:0] level_t;
    typedef logic [TIME_W-1:0]         time_t;

    // One queued sample with the time at which it arrived.
    typedef struct packed {
        chan_t  channel;
        level_t level;
        time_t  stamp;
    } sample_t;

    // Configuration register file.
    typedef struct packed {
        logic signed [DECAY_W-1:0] decay_db;
        time_t                     period;
        time_t                     hold;
    } cfg_t;

    // Per-channel meter state as kept in the state RAM.
    typedef struct packed {
        level_t bar;
        level_t peak;
        time_t  decay_start;
        level_t hold;
        time_t  hold_start;
    } chan_state_t;

    localparam int CHAN_STATE_W = $bits(chan_state_t);

endpackage

/* design/pmdh_in_if.sv */
// Input channel of the peak meter: valid/ready handshake carrying one item.
// Depends on pmdh_pkg.
interface pmdh_in_if;
    import pmdh_pkg::*;

    logic   valid;
    logic   ready;
    logic   mode;
    chan_t  channel;
    level_t level_db;

    modport source (output valid, output mode, output channel, output level_db, input ready);
    modport sink   (input valid, input mode, input channel, input level_db, output ready);
endinterface

/* design/pmdh_out_if.sv */
// Result channel of the peak meter: valid/ready handshake carrying one result.
// Depends on pmdh_pkg.
interface pmdh_out_if;
    import pmdh_pkg::*;

    logic   valid;
    logic   ready;
    chan_t  out_channel;
    level_t bar_db;
    level_t hold_db;

    modport source (output valid, output out_channel, output bar_db, output hold_db,
                    input ready);
    modport sink   (input valid, input out_channel, input bar_db, input hold_db,
                    output ready);
endinterface

/* design/pmdh_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module pmdh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* design/pmdh_div.sv */
// Iterative unsigned restoring divider, one quotient bit per cycle.
// Depends on pmdh_pkg.
module pmdh_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [pmdh_pkg::MAG_W-1:0]     dividend,
    input  logic [pmdh_pkg::TIME_W-1:0]    divisor,
    output logic                           done,
    output logic [pmdh_pkg::MAG_W-1:0]     quotient
);
    import pmdh_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [TIME_W-1:0]    rem_reg, rem_next;
    logic [MAG_W-1:0]     quo_reg, quo_next;
    logic [TIME_W-1:0]    dvs_reg, dvs_next;
    logic [TIME_W:0]      trial;
    logic [TIME_W:0]      diff;

    // One restoring step: shift in the next dividend bit and try a subtract.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        trial     = {rem_reg, quo_reg[MAG_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(MAG_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = diff[TIME_W-1:0];
                quo_next = {quo_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[TIME_W-1:0];
                quo_next = {quo_reg[MAG_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* design/pmdh_front.sv */
// Front end: accepts words, keeps the tick counter and queues time-stamped samples.
// Depends on pmdh_pkg and pmdh_in_if.
module pmdh_front (
    input  logic              clk,
    input  logic              rst_n,
    pmdh_in_if.sink           items,
    output logic              q_valid,
    input  logic              q_ready,
    output pmdh_pkg::sample_t q_data
);
    import pmdh_pkg::*;

    time_t             time_reg, time_next;
    sample_t           fifo_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              accept;
    logic              push;
    logic              pop;

    assign items.ready = (count_reg != QCNT_W'(QDEPTH));
    assign accept      = items.valid && items.ready;
    assign push        = accept && (items.mode == MODE_SAMPLE)
                         && (int'(items.channel) < CHANNELS);
    assign pop         = q_valid && q_ready;

    // Ticks advance time here; samples are queued with the current time.
    always_comb
    begin
        time_next   = time_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept && (items.mode == MODE_TICK))
        begin
            time_next = time_reg + 1'b1;
        end
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg   <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            time_reg   <= time_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= '{channel: items.channel, level: items.level_db,
                                      stamp: time_reg};
        end
    end

    assign q_valid = (count_reg != '0);
    assign q_data  = fifo_reg[rd_ptr_reg];

endmodule

/* design/pmdh_back.sv */
// Back end: per-sample sequencer over the channel state RAM, decay multiply and divide.
// Depends on pmdh_pkg, pmdh_out_if, pmdh_ram and pmdh_div.
module pmdh_back (
    input  logic              clk,
    input  logic              rst_n,
    input  pmdh_pkg::cfg_t    cfg,
    input  logic              q_valid,
    output logic              q_ready,
    input  pmdh_pkg::sample_t q_data,
    pmdh_out_if.source        results
);
    import pmdh_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_LOAD     = 3'd1;
    localparam logic [2:0] ST_MUL      = 3'd2;
    localparam logic [2:0] ST_DIV_GO   = 3'd3;
    localparam logic [2:0] ST_DIV_WAIT = 3'd4;
    localparam logic [2:0] ST_FIN      = 3'd5;
    localparam logic [2:0] ST_WRITE    = 3'd6;

    logic [2:0]               state_reg, state_next;
    sample_t                  cur_reg, cur_next;
    chan_state_t              st_reg, st_next;
    time_t                    elapsed_reg, elapsed_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic [CHANNELS-1:0]      valid_reg, valid_next;
    logic                     out_valid_reg, out_valid_next;
    chan_t                    out_chan_reg, out_chan_next;
    level_t                   out_bar_reg, out_bar_next;
    level_t                   out_hold_reg, out_hold_next;

    logic [CH_AW-1:0]         cur_addr;
    logic [CH_AW-1:0]         ram_raddr;
    logic                     ram_we;
    chan_state_t              ram_rdata;
    chan_state_t              st_in;
    level_t                   lvl;
    logic                     rise;
    logic                     hold_refresh;
    logic                     out_free;
    logic                     div_start;
    logic                     div_done;
    logic [MAG_W-1:0]         div_quot;
    logic signed [PROD_W-1:0] prod_abs;
    time_t                    period_eff;
    logic signed [PROD_W-1:0] q_signed;
    logic signed [PROD_W-1:0] sum;
    logic signed [PROD_W-1:0] clamped;

    assign cur_addr   = CH_AW'(cur_reg.channel);
    assign ram_raddr  = CH_AW'(q_data.channel);
    assign out_free   = !out_valid_reg || results.ready;
    assign period_eff = (cfg.period == '0) ? TIME_W'(1) : cfg.period;
    assign prod_abs   = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;
    assign lvl        = cur_reg.level;

    // A channel never written reads as all zero.
    assign st_in = valid_reg[cur_addr] ? ram_rdata : '0;
    assign rise  = lvl >= $signed(st_in.bar);
    assign hold_refresh = !valid_reg[cur_addr]
                          || ((cur_reg.stamp - st_in.hold_start) >= cfg.hold);

    // Signed decay term and clamped bar.
    assign q_signed = prod_reg[PROD_W-1]
                      ? -$signed({{(PROD_W - MAG_W){1'b0}}, div_quot})
                      : $signed({{(PROD_W - MAG_W){1'b0}}, div_quot});
    assign sum      = $signed({{(PROD_W - LEVEL_W){st_reg.peak[LEVEL_W-1]}}, st_reg.peak})
                      + q_signed;
    assign clamped  = (sum < SUM_MIN) ? SUM_MIN : ((sum > SUM_MAX) ? SUM_MAX : sum);

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        st_next        = st_reg;
        elapsed_next   = elapsed_reg;
        prod_next      = prod_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_chan_next  = out_chan_reg;
        out_bar_next   = out_bar_reg;
        out_hold_next  = out_hold_reg;
        q_ready        = 1'b0;
        ram_we         = 1'b0;
        div_start      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                q_ready = q_valid;
                if (q_valid)
                begin
                    cur_next   = q_data;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                st_next = st_in;
                if (hold_refresh)
                begin
                    st_next.hold       = lvl;
                    st_next.hold_start = cur_reg.stamp;
                end
                if (rise)
                begin
                    st_next.bar         = lvl;
                    st_next.peak        = lvl;
                    st_next.decay_start = cur_reg.stamp;
                    state_next          = ST_WRITE;
                end
                else
                begin
                    state_next = ST_MUL;
                end
                elapsed_next = cur_reg.stamp - st_in.decay_start;
            end
            ST_MUL:
            begin
                prod_next  = cfg.decay_db * $signed({1'b0, elapsed_reg});
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                st_next.bar = clamped[LEVEL_W-1:0];
                state_next  = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_free)
                begin
                    ram_we               = 1'b1;
                    valid_next[cur_addr] = 1'b1;
                    out_valid_next       = 1'b1;
                    out_chan_next        = cur_reg.channel;
                    out_bar_next         = st_reg.bar;
                    out_hold_next        = st_reg.hold;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath and result registers.
    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        st_reg       <= st_next;
        elapsed_reg  <= elapsed_next;
        prod_reg     <= prod_next;
        out_chan_reg <= out_chan_next;
        out_bar_reg  <= out_bar_next;
        out_hold_reg <= out_hold_next;
    end

    // Per-channel state store.
    pmdh_ram #(
        .WIDTH (CHAN_STATE_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cur_addr),
        .wdata (st_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Decay term divider.
    pmdh_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_abs[MAG_W-1:0]),
        .divisor  (period_eff),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign results.valid       = out_valid_reg;
    assign results.out_channel = out_chan_reg;
    assign results.bar_db      = out_bar_reg;
    assign results.hold_db     = out_hold_reg;

endmodule

/* design/peak_meter_decay_hold.sv */
// Per-channel peak meter with decaying bar and peak hold.
// A tick word only advances time. A sample at or above the bar passes the load and
// write states; one below it also passes the multiply and the 39-step iterative
// divider. The back end takes no new sample until the last result is in the output
// register; a two-entry queue lets the front end keep taking words meanwhile. Reset
// clears time, the channel valid bits (all read as 0 dB) and loads the configuration defaults.
module peak_meter_decay_hold (
    input  logic                              clk,
    input  logic                              rst_n,
    pmdh_in_if.sink                           items,
    pmdh_out_if.source                        results,
    input  logic                              cfg_wr_en,
    input  logic [pmdh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pmdh_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pmdh_pkg::*;

    cfg_t    cfg_reg;
    logic    q_valid;
    logic    q_ready;
    sample_t q_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.decay_db <= DECAY_DB_RST;
            cfg_reg.period   <= PERIOD_RST;
            cfg_reg.hold     <= HOLD_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_DECAY_DB:   cfg_reg.decay_db <= cfg_data[DECAY_W-1:0];
                REG_PERIOD:     cfg_reg.period   <= cfg_data[TIME_W-1:0];
                REG_HOLD_TICKS: cfg_reg.hold     <= cfg_data[TIME_W-1:0];
                default:        ;
            endcase
        end
    end

    pmdh_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data)
    );

    pmdh_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data),
        .results (results)
    );

    // A tick never creates a queue entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (items.valid && items.ready && (items.mode == MODE_TICK) && !q_valid) |=> !q_valid)
        else $error("tick word entered the sample queue");

    // A sample taken into an empty queue is offered to the back end next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (items.valid && items.ready && (items.mode == MODE_SAMPLE)
         && (int'(items.channel) < CHANNELS) && !q_valid) |=> q_valid)
        else $error("accepted sample missing from the queue");

    // After taking a sample the back end is busy and takes no other.
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && q_ready) |=> !q_ready)
        else $error("back end took two samples in a row");

endmodule

/* tb/peak_meter_decay_hold_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the per-channel peak meter with decaying bar and peak hold.
// A scoreboard class predicts each reading from the accepted words; depends on pmdh_pkg,
// pmdh_in_if, pmdh_out_if and peak_meter_decay_hold.
module peak_meter_decay_hold_tb;
    import pmdh_pkg::*;

    // One expected reading of the meter.
    typedef struct {
        chan_t  channel;
        level_t bar;
        level_t hold;
    } reading_t;

    // Predicts the meter readings and compares them with what the block returns.
    class meter_scoreboard;
        level_t   decay_db;
        time_t    period;
        time_t    hold_len;
        time_t    now;
        level_t   bar [CHANNELS];
        level_t   peak [CHANNELS];
        time_t    decay_t0 [CHANNELS];
        level_t   held_level [CHANNELS];
        time_t    hold_t0 [CHANNELS];
        bit       holding [CHANNELS];
        reading_t expected_q [$];
        int       errors;
        int       checked;

        function new();
            decay_db = DECAY_DB_RST;
            period   = PERIOD_RST;
            hold_len = HOLD_RST;
            now      = '0;
            errors   = 0;
            checked  = 0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                bar[c]        = '0;
                peak[c]       = '0;
                decay_t0[c]   = '0;
                held_level[c] = '0;
                hold_t0[c]    = '0;
                holding[c]    = 1'b0;
            end
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_DECAY_DB:   decay_db = level_t'(data[DECAY_W-1:0]);
                REG_PERIOD:     period = data;
                REG_HOLD_TICKS: hold_len = data;
                default: ;
            endcase
        endfunction

        // Bar fallen from the decay peak, computed wide, truncated toward zero, clamped.
        function level_t decayed_bar(int c);
            time_t   elapsed;
            time_t   divisor;
            longint  prod;
            longint  v;
            elapsed = now - decay_t0[c];
            divisor = (period == '0) ? time_t'(1) : period;
            prod = longint'(decay_db) * longint'({32'd0, elapsed});
            v = longint'(peak[c]) + prod / longint'({32'd0, divisor});
            if (v < -128)
                v = -128;
            if (v > 127)
                v = 127;
            return level_t'(v[LEVEL_W-1:0]);
        endfunction

        function void note_word(logic mode, chan_t ch, level_t lvl);
            int       c;
            time_t    since_hold;
            reading_t r;
            if (mode == MODE_TICK)
            begin
                now = now + 1;
                return;
            end
            c = int'(ch);
            if (c >= CHANNELS)
                return;

            // A level at or above the bar restarts the decay; otherwise the bar falls.
            if (lvl >= bar[c])
            begin
                bar[c]      = lvl;
                peak[c]     = lvl;
                decay_t0[c] = now;
            end
            else
                bar[c] = decayed_bar(c);

            // The held peak refreshes on the first sample or once the hold time is up.
            since_hold = now - hold_t0[c];
            if (!holding[c] || since_hold >= hold_len)
            begin
                held_level[c] = lvl;
                hold_t0[c]    = now;
                holding[c]    = 1'b1;
            end

            r.channel = ch;
            r.bar     = bar[c];
            r.hold    = held_level[c];
            expected_q.push_back(r);
        endfunction

        function void check_reading(chan_t ch, level_t bar_db, level_t hold_db);
            reading_t r;
            if (expected_q.size() == 0)
            begin
                $error("reading on channel %0d arrived with none expected", ch);
                errors++;
                return;
            end
            r = expected_q.pop_front();
            checked++;
            if (ch !== r.channel)
            begin
                $error("out_channel mismatch: expected %0d, actual %0d", r.channel, ch);
                errors++;
            end
            if (bar_db !== r.bar)
            begin
                $error("bar_db mismatch: expected %0d, actual %0d", r.bar, bar_db);
                errors++;
            end
            if (hold_db !== r.hold)
            begin
                $error("hold_db mismatch: expected %0d, actual %0d", r.hold, hold_db);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int send_idle = 34;
    int recv_idle = 86;
    int n_samples = 0;
    int n_ticks = 0;
    int n_settings = 0;

    meter_scoreboard meter = new();

    pmdh_in_if  item_bus ();
    pmdh_out_if result_bus ();

    peak_meter_decay_hold u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .items     (item_bus),
        .results   (result_bus),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Result side: random stalls, and every accepted reading is checked.
    initial
    begin
        result_bus.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
                meter.check_reading(result_bus.out_channel, result_bus.bar_db,
                                    result_bus.hold_db);
            result_bus.ready <= rst_n && ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // Offers one word, with random idle cycles ahead of it, and waits until it is taken.
    task automatic send_word(logic mode, chan_t ch, level_t lvl);
        while ($urandom_range(0, 99) < send_idle)
        begin
            item_bus.valid <= 1'b0;
            @(posedge clk);
        end
        item_bus.valid    <= 1'b1;
        item_bus.mode     <= mode;
        item_bus.channel  <= ch;
        item_bus.level_db <= lvl;
        do
            @(posedge clk);
        while (item_bus.ready !== 1'b1);
        meter.note_word(mode, ch, lvl);
        if (mode == MODE_TICK)
            n_ticks++;
        else
            n_samples++;
    endtask

    task automatic send_tick();
        send_word(MODE_TICK, chan_t'($urandom_range(0, 7)), level_t'($urandom_range(0, 255)));
    endtask

    // Holds the input back until every predicted reading has come out.
    task automatic drain_readings();
        item_bus.valid <= 1'b0;
        do
            @(posedge clk);
        while (meter.pending() != 0);
    endtask

    // Drains, then lets a bar decay in flight finish before registers change.
    task automatic settle();
        drain_readings();
        repeat (60) @(posedge clk);
    endtask

    // Writes all three registers in consecutive cycles.
    task automatic load_settings(int decay, time_t period, time_t hold_len);
        level_t decay_lvl;
        logic [CFG_DATA_W-1:0] decay_word;
        decay_lvl  = level_t'(decay);
        decay_word = {{(CFG_DATA_W - DECAY_W){decay_lvl[DECAY_W-1]}}, decay_lvl};
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_DECAY_DB;
        cfg_data  <= decay_word;
        @(posedge clk);
        meter.set_reg(REG_DECAY_DB, decay_word);
        cfg_index <= REG_PERIOD;
        cfg_data  <= period;
        @(posedge clk);
        meter.set_reg(REG_PERIOD, period);
        cfg_index <= REG_HOLD_TICKS;
        cfg_data  <= hold_len;
        @(posedge clk);
        meter.set_reg(REG_HOLD_TICKS, hold_len);
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    // Random words under one setting: samples, single ticks, tick bursts and pauses.
    task automatic run_phase(int decay, time_t period, time_t hold_len, int count);
        int n;
        int r;
        int burst;
        int v;
        settle();
        load_settings(decay, period, hold_len);
        n = 0;
        while (n < count)
        begin
            r = $urandom_range(0, 99);
            if (r < 2)
                drain_readings();
            else if (r < 7)
            begin
                burst = $urandom_range(5, 40);
                repeat (burst) send_tick();
                n += burst;
            end
            else if (r < 40)
            begin
                send_tick();
                n++;
            end
            else
            begin
                // Mostly levels in the meter range, some above it.
                if ($urandom_range(0, 7) == 0)
                    v = $urandom_range(0, 255);
                else
                    v = $urandom_range(0, 152) - 128;
                send_word(MODE_SAMPLE, chan_t'($urandom_range(0, 7)), level_t'(v));
                n++;
            end
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_wr_en         = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        item_bus.valid    = 1'b0;
        item_bus.mode     = MODE_SAMPLE;
        item_bus.channel  = '0;
        item_bus.level_db = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset settings: first samples on every channel,
        // level extremes, a level equal to the bar, levels above range, and ticks.
        send_word(MODE_SAMPLE, 3'd0, -8'sd128);
        send_word(MODE_SAMPLE, 3'd1, 8'sd127);
        send_word(MODE_SAMPLE, 3'd2, 8'sd24);
        send_word(MODE_SAMPLE, 3'd3, 8'sd0);
        send_word(MODE_SAMPLE, 3'd4, -8'sd1);
        send_word(MODE_SAMPLE, 3'd5, 8'sd85);
        send_word(MODE_SAMPLE, 3'd6, -8'sd86);
        send_word(MODE_SAMPLE, 3'd7, -8'sd127);
        send_word(MODE_TICK, 3'd7, 8'sd127);
        send_word(MODE_TICK, 3'd0, -8'sd128);
        send_word(MODE_TICK, 3'd5, 8'sd85);
        send_word(MODE_SAMPLE, 3'd1, -8'sd128);
        send_word(MODE_SAMPLE, 3'd0, 8'sd24);
        send_word(MODE_SAMPLE, 3'd2, 8'sd24);
        send_word(MODE_SAMPLE, 3'd3, -8'sd128);
        send_word(MODE_SAMPLE, 3'd4, 8'sd100);
        send_word(MODE_SAMPLE, 3'd6, 8'sd0);
        send_word(MODE_SAMPLE, 3'd7, 8'sd127);

        // Random phases; the first three stall mostly on the result side,
        // the next three mostly on the input side, the rest run without gaps.
        run_phase(-128, 32'd1, 32'd0, 80);
        run_phase(-55, 32'd0, 32'd5, 80);
        run_phase(-1, 32'd4, 32'd20, 80);
        send_idle = 86;
        recv_idle = 34;
        run_phase(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 80);
        run_phase(100, 32'd7, 32'd3, 80);
        run_phase(-128, 32'hFFFF_FFFF, 32'd1, 80);
        send_idle = 0;
        recv_idle = 0;
        run_phase(-20, 32'd10, 32'd12, 80);
        run_phase(127, 32'd1, 32'd0, 80);
        run_phase(-9, 32'd3, 32'd40, 80);
        run_phase(-55, 32'd1500000, 32'd300000, 80);

        settle();
        meter.errors += meter.pending();
        $display("Covered %0d samples and %0d ticks under %0d register settings;",
                 n_samples, n_ticks, n_settings + 1);
        $display("%0d readings were compared field by field.", meter.checked);
        if (meter.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog in case the block stops answering.
    initial
    begin
        #8_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
